FILE: rtl/core/kps_pkg.sv
// Package for the key and payload sorter.
// Holds the item and result struct types, default sizes and the controller state codes.
// No dependencies.
package kps_pkg;

  localparam int unsigned FIELD_BITS           = 32;
  localparam int unsigned MAX_BITS             = 64;
  localparam int unsigned DEFAULT_DEPTH        = 64;
  localparam int unsigned DEFAULT_KEY_BITS     = 32;
  localparam int unsigned DEFAULT_PAYLOAD_BITS = 32;

  typedef struct packed {
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] payload;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] sorted_key;
    logic [FIELD_BITS-1:0] sorted_payload;
    logic                  end_of_run;
    logic                  overflow;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SHIFT   = 5'b00010,
    ST_PLACE   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

endpackage

FILE: rtl/core/kps_mem.sv
// Pair store of the sorter: one write port and one read port, registered read data.
// Depends on nothing but its parameters.
module kps_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled output can pick it up later.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/key_payload_sorter.sv
// Stable key and payload sorter built around one pair store with registered read data.
// Each item is placed by insertion: every stored pair with a larger key moves up one entry,
// then the item is written; an item that arrives at a full store is dropped.
// The store has one read and one write port; items are taken one at a time.
// Once the last item of a set is placed, results follow through ST_EMIT_RD and ST_EMIT at one per
// cycle while not stalled. Reset (synchronous) empties the store and clears the overflow mark; data is kept.
module key_payload_sorter
  import kps_pkg::*;
#(
  parameter int unsigned DEPTH        = DEFAULT_DEPTH,
  parameter int unsigned KEY_BITS     = DEFAULT_KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

  state_t                  state, state_next;
  logic [CW-1:0]           fill, fill_next;
  logic                    dropped, dropped_next;
  logic [AW-1:0]           pos, pos_next;
  logic [AW-1:0]           idx, idx_next;
  logic                    result_valid_next;
  logic [KEY_BITS-1:0]     cur_key, cur_key_next;
  logic [PAYLOAD_BITS-1:0] cur_payload, cur_payload_next;
  logic                    cur_last, cur_last_next;
  result_t                 result_next;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [EW-1:0]           wr_data, rd_data;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [MAX_BITS-1:0]     in_key_ext, in_payload_ext, out_key_ext, out_payload_ext;
  logic [AW-1:0]           pos_dec;
  logic                    accept, load, run_end;

  kps_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key          = rd_data[EW-1:PAYLOAD_BITS];
  assign rd_payload      = rd_data[PAYLOAD_BITS-1:0];
  assign in_key_ext      = MAX_BITS'(item.key);
  assign in_payload_ext  = MAX_BITS'(item.payload);
  assign out_key_ext     = MAX_BITS'(rd_key);
  assign out_payload_ext = MAX_BITS'(rd_payload);
  assign pos_dec         = pos - 1'b1;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign load       = (state == ST_EMIT) && (!result_valid || !result_stall);
  assign run_end    = ((CW'(idx) + 1'b1) == fill);

  always_comb begin
    state_next        = state;
    fill_next         = fill;
    dropped_next      = dropped;
    pos_next          = pos;
    idx_next          = idx;
    cur_key_next      = cur_key;
    cur_payload_next  = cur_payload;
    cur_last_next     = cur_last;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    wr_en             = 1'b0;
    wr_addr           = pos;
    wr_data           = {cur_key, cur_payload};
    rd_en             = 1'b0;
    rd_addr           = pos_dec;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_key_next     = in_key_ext[KEY_BITS-1:0];
          cur_payload_next = in_payload_ext[PAYLOAD_BITS-1:0];
          cur_last_next    = item.last;
          pos_next         = fill[AW-1:0];
          idx_next         = '0;
          if (fill == CW'(DEPTH)) begin
            // Store full: the item is dropped, but a last item still ends the set.
            dropped_next = 1'b1;
            state_next   = item.last ? ST_EMIT_RD : ST_IDLE;
          end else if (fill == '0) begin
            state_next = ST_PLACE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = fill[AW-1:0] - 1'b1;
            state_next = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // The entry just below pos is in rd_data; strict compare keeps equal keys in order.
        if (rd_key > cur_key) begin
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = pos_dec;
          if (pos > AW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos_dec - 1'b1;
          end else begin
            state_next = ST_PLACE;
          end
        end else begin
          wr_en      = 1'b1;
          fill_next  = fill + 1'b1;
          state_next = cur_last ? ST_EMIT_RD : ST_IDLE;
        end
      end

      ST_PLACE: begin
        wr_en      = 1'b1;
        fill_next  = fill + 1'b1;
        state_next = cur_last ? ST_EMIT_RD : ST_IDLE;
      end

      ST_EMIT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (load) begin
          result_valid_next          = 1'b1;
          result_next.sorted_key     = out_key_ext[FIELD_BITS-1:0];
          result_next.sorted_payload = out_payload_ext[FIELD_BITS-1:0];
          result_next.end_of_run     = run_end;
          result_next.overflow       = dropped;
          if (run_end) begin
            fill_next    = '0;
            dropped_next = 1'b0;
            state_next   = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      dropped      <= dropped_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    idx         <= idx_next;
    cur_key     <= cur_key_next;
    cur_payload <= cur_payload_next;
    cur_last    <= cur_last_next;
    result      <= result_next;
  end

  a_shift_above_bottom: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> pos != '0)
    else $error("insertion shift running at the bottom entry");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_EMIT_RD) |-> fill != '0)
    else $error("emitting a run from an empty store");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    load && run_end |=> fill == '0 && !dropped && state == ST_IDLE)
    else $error("store not emptied after the last item of a run");

endmodule

FILE: bench/sort_order_checker.sv
// Checker for the key and payload sorter: watches both channels, keeps its own sorted store
// and compares every result with the pair expected next in the run.
// Depends on kps_pkg for the item and result types.
module sort_order_checker
  import kps_pkg::*;
#(
  parameter int unsigned DEPTH        = DEFAULT_DEPTH,
  parameter int unsigned KEY_BITS     = DEFAULT_KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FIELD_BITS-1:0] KEY_MASK =
    (KEY_BITS >= FIELD_BITS) ? '1 : ((FIELD_BITS'(1) << KEY_BITS) - 1);
  localparam logic [FIELD_BITS-1:0] PAYLOAD_MASK =
    (PAYLOAD_BITS >= FIELD_BITS) ? '1 : ((FIELD_BITS'(1) << PAYLOAD_BITS) - 1);
  localparam int PRINT_CAP = 30;

  // Stored pairs, always kept in ascending key order.
  logic [FIELD_BITS-1:0] held_key_q[$];
  logic [FIELD_BITS-1:0] held_payload_q[$];
  bit                    pairs_dropped;
  result_t               sorted_run_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] sorter mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Stable insertion: a new pair goes after every stored pair whose key is not larger.
  function automatic void place_pair(input item_t it);
    int      pos;
    result_t run_entry;
    if (held_key_q.size() < DEPTH) begin
      pos = held_key_q.size();
      while (pos > 0 && held_key_q[pos-1] > (it.key & KEY_MASK)) pos--;
      held_key_q.insert(pos, it.key & KEY_MASK);
      held_payload_q.insert(pos, it.payload & PAYLOAD_MASK);
    end else begin
      pairs_dropped = 1'b1;
    end
    if (it.last) begin
      for (int i = 0; i < held_key_q.size(); i++) begin
        run_entry.sorted_key     = held_key_q[i];
        run_entry.sorted_payload = held_payload_q[i];
        run_entry.end_of_run     = (i == held_key_q.size() - 1);
        run_entry.overflow       = pairs_dropped;
        sorted_run_q.push_back(run_entry);
      end
      held_key_q.delete();
      held_payload_q.delete();
      pairs_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held_key_q.delete();
      held_payload_q.delete();
      sorted_run_q.delete();
      pairs_dropped = 1'b0;
    end else begin
      if (item_valid && !item_stall) place_pair(item);
      if (result_valid && !result_stall) begin
        if (sorted_run_q.size() == 0) begin
          flag_mismatch($sformatf("result %h arrived with nothing expected", result));
        end else begin
          want = sorted_run_q.pop_front();
          if (result.sorted_key !== want.sorted_key)
            flag_mismatch($sformatf("sorted_key %h, expected %h",
                                    result.sorted_key, want.sorted_key));
          if (result.sorted_payload !== want.sorted_payload)
            flag_mismatch($sformatf("sorted_payload %h, expected %h (key %h)",
                                    result.sorted_payload, want.sorted_payload,
                                    want.sorted_key));
          if (result.end_of_run !== want.end_of_run)
            flag_mismatch($sformatf("end_of_run %b, expected %b (key %h)",
                                    result.end_of_run, want.end_of_run, want.sorted_key));
          if (result.overflow !== want.overflow)
            flag_mismatch($sformatf("overflow %b, expected %b (key %h)",
                                    result.overflow, want.overflow, want.sorted_key));
        end
      end
    end
    outstanding = sorted_run_q.size();
  end

endmodule

FILE: bench/tb_key_payload_sorter.sv
// Top of the key and payload sorter bench: clock, reset, item stimulus and result stalls.
// Instantiates key_payload_sorter and sort_order_checker; depends on kps_pkg.
module tb_key_payload_sorter
  import kps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SORT_DEPTH   = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  key_payload_sorter #(
    .DEPTH        (SORT_DEPTH),
    .KEY_BITS     (DEFAULT_KEY_BITS),
    .PAYLOAD_BITS (DEFAULT_PAYLOAD_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sort_order_checker #(
    .DEPTH        (SORT_DEPTH),
    .KEY_BITS     (DEFAULT_KEY_BITS),
    .PAYLOAD_BITS (DEFAULT_PAYLOAD_BITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Narrow keys give many duplicates, which exercises stability.
  function automatic logic [FIELD_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 7);
    if (r == 4) return '0;
    if (r == 5) return '1;
    return $urandom;
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Result side stalls; calm stretches have no idling on either side.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= pick_gap();
    end else begin
      result_stall <= 1'b0;
    end
    if ($urandom_range(0, 299) == 0) calm <= !calm;
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    // Stall is stable by the falling edge; the item goes in at the next rising edge.
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_pair(input logic [FIELD_BITS-1:0] k, input logic [FIELD_BITS-1:0] p,
                           input logic is_last);
    item_t it;
    it.key     = k;
    it.payload = p;
    it.last    = is_last;
    send_item(it);
  endtask

  task automatic send_random_set(input int size);
    for (int i = 0; i < size; i++) begin
      send_pair(pick_key(), pick_payload(), i == size - 1);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sent;
    int r;
    int size;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single-pair sets at both ends of the key and payload range.
    send_pair('0, '0, 1'b1);
    send_pair('1, '1, 1'b1);
    // Equal keys must come out in arrival order.
    send_pair(32'd5, 32'h1, 1'b0);
    send_pair(32'd5, 32'h2, 1'b0);
    send_pair(32'd5, 32'h3, 1'b1);
    // Descending keys make every insertion walk the whole store.
    for (int i = 8; i >= 1; i--) begin
      send_pair(i, 32'hA000_0000 | i, i == 1);
    end
    send_pair('1, 32'h0000_0001, 1'b0);
    send_pair('0, 32'h0000_0002, 1'b0);
    send_pair('1, 32'h0000_0003, 1'b0);
    send_pair('0, 32'h0000_0004, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

    // A set two pairs beyond the store depth: dropped pairs with and without last.
    send_random_set(SORT_DEPTH + 2);
    sent = SORT_DEPTH + 2;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) size = $urandom_range(SORT_DEPTH - 1, SORT_DEPTH + 1);
      else if (r < 15) size = $urandom_range(13, 30);
      else size = $urandom_range(1, 12);
      send_random_set(size);
      sent += size;
    end
    item_valid <= 1'b0;

    // One more edge so the checker has taken the final item before the count is read.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/kps_pkg.sv
rtl/core/kps_mem.sv
rtl/core/key_payload_sorter.sv
bench/sort_order_checker.sv
bench/tb_key_payload_sorter.sv
